@@ hw/rtl/wfrm_pkg.sv @@
// shared types and constants of the weighted frame rate meter
// used by wfrm_muldiv and weighted_frame_rate_meter; depends on nothing
`timescale 1ns / 1ps

package wfrm_pkg;

    // history length; weight of entry k (0 = oldest) is 2^(k+1)
    localparam int HISTORY_DEPTH = 5;

    // field widths
    localparam int TIME_W   = 32;
    localparam int FRAME_W  = 16;
    localparam int TICK_W   = 16;
    localparam int TPS_W    = 16;
    localparam int RATE_W   = 24;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // weighted sum fits below 2^(16 + depth + 1)
    localparam int SUM_W    = FRAME_W + HISTORY_DEPTH + 1;
    // sum times 100 needs seven more bits
    localparam int F100_W   = SUM_W + 7;
    localparam int NUM_W    = F100_W + TPS_W;
    localparam int HCNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int MCNT_W   = $clog2(RATE_W);

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_LEN         = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = CFG_IDX_W'(1);

    localparam logic [TICK_W-1:0] SPAN_LEN_RST         = TICK_W'(1000);
    localparam logic [TPS_W-1:0]  TICKS_PER_SECOND_RST = TPS_W'(1000);

    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [F100_W-1:0] f100_t;

    // control sequencer of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LAUNCH,
        ST_CALC,
        ST_HOLD
    } state_t;

    // multiply / divide unit sequencer
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHECK,
        MD_DIV
    } md_state_t;

    // status of the multiply / divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

endpackage

@@ hw/rtl/wfrm_muldiv.sv @@
// bit-serial rate unit: sum * 100 * ticks_per_second / tick sum, saturated
// depends on wfrm_pkg
`timescale 1ns / 1ps

module wfrm_muldiv
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [wfrm_pkg::SUM_W-1:0]       fsum,
    input  logic [wfrm_pkg::SUM_W-1:0]       tsum,
    input  logic [wfrm_pkg::TPS_W-1:0]       tps,
    output logic [wfrm_pkg::RATE_W-1:0]      rate,
    output wfrm_pkg::md_stat_t               stat
);

    wfrm_pkg::md_state_t state_reg, state_next;

    logic [wfrm_pkg::MCNT_W-1:0] cnt_reg;
    logic [wfrm_pkg::F100_W-1:0] f100_reg;
    logic [wfrm_pkg::SUM_W-1:0]  tsum_reg;
    logic [wfrm_pkg::TPS_W-1:0]  tps_sh_reg;
    logic [wfrm_pkg::NUM_W-1:0]  p_reg;
    logic [wfrm_pkg::SUM_W-1:0]  rem_reg;
    logic [wfrm_pkg::RATE_W-1:0] q_reg;

    wfrm_pkg::f100_t             f100;
    logic [wfrm_pkg::F100_W:0]   mul_hi;
    wfrm_pkg::sum_t              num_hi;
    logic                        sat;
    logic [wfrm_pkg::SUM_W:0]    trial;
    logic [wfrm_pkg::SUM_W:0]    diff;
    logic                        ge;
    logic                        mul_last;
    logic                        div_last;

    // 100 = 64 + 32 + 4
    assign f100 = (wfrm_pkg::f100_t'(fsum) << 6) + (wfrm_pkg::f100_t'(fsum) << 5)
                + (wfrm_pkg::f100_t'(fsum) << 2);

    // one multiplier bit per cycle, lsb first, partial sum added at the top
    assign mul_hi = {1'b0, p_reg[wfrm_pkg::NUM_W-1:wfrm_pkg::TPS_W]}
                  + (tps_sh_reg[0] ? {1'b0, f100_reg} : '0);

    // quotient overflows 24 bits exactly when num / 2^24 >= divisor
    assign num_hi = wfrm_pkg::sum_t'(p_reg[wfrm_pkg::NUM_W-1:wfrm_pkg::RATE_W]);
    assign sat    = (num_hi >= tsum_reg);

    // restoring divide step, one quotient bit per cycle
    assign trial = {rem_reg, q_reg[wfrm_pkg::RATE_W-1]};
    assign diff  = trial - {1'b0, tsum_reg};
    assign ge    = (trial >= {1'b0, tsum_reg});

    assign mul_last = (cnt_reg == wfrm_pkg::MCNT_W'(wfrm_pkg::TPS_W - 1));
    assign div_last = (cnt_reg == wfrm_pkg::MCNT_W'(wfrm_pkg::RATE_W - 1));

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfrm_pkg::MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and status
    always_comb
    begin
        state_next = state_reg;
        stat.busy  = (state_reg != wfrm_pkg::MD_IDLE);
        stat.done  = 1'b0;
        unique case (state_reg)
            wfrm_pkg::MD_IDLE:
            begin
                if (start)
                begin
                    state_next = wfrm_pkg::MD_MUL;
                end
            end
            wfrm_pkg::MD_MUL:
            begin
                if (mul_last)
                begin
                    state_next = wfrm_pkg::MD_CHECK;
                end
            end
            wfrm_pkg::MD_CHECK:
            begin
                if (sat)
                begin
                    stat.done  = 1'b1;
                    state_next = wfrm_pkg::MD_IDLE;
                end
                else
                begin
                    state_next = wfrm_pkg::MD_DIV;
                end
            end
            wfrm_pkg::MD_DIV:
            begin
                if (div_last)
                begin
                    stat.done  = 1'b1;
                    state_next = wfrm_pkg::MD_IDLE;
                end
            end
            default:
            begin
                state_next = wfrm_pkg::MD_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            wfrm_pkg::MD_IDLE:
            begin
                if (start)
                begin
                    f100_reg   <= f100;
                    tsum_reg   <= tsum;
                    tps_sh_reg <= tps;
                    p_reg      <= '0;
                    cnt_reg    <= '0;
                end
            end
            wfrm_pkg::MD_MUL:
            begin
                p_reg      <= {mul_hi, p_reg[wfrm_pkg::TPS_W-1:1]};
                tps_sh_reg <= tps_sh_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            wfrm_pkg::MD_CHECK:
            begin
                cnt_reg <= '0;
                if (sat)
                begin
                    q_reg <= wfrm_pkg::RATE_MAX;
                end
                else
                begin
                    rem_reg <= num_hi;
                    q_reg   <= p_reg[wfrm_pkg::RATE_W-1:0];
                end
            end
            wfrm_pkg::MD_DIV:
            begin
                rem_reg <= ge ? diff[wfrm_pkg::SUM_W-1:0] : trial[wfrm_pkg::SUM_W-1:0];
                q_reg   <= {q_reg[wfrm_pkg::RATE_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign rate = q_reg;

    // partial remainder always stays below the divisor
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wfrm_pkg::MD_DIV) |-> (rem_reg < tsum_reg))
        else $error("divide remainder not below divisor");

    // a new start is only issued while the unit is idle
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == wfrm_pkg::MD_IDLE))
        else $error("rate unit started while busy");

    // the unit is idle again once it has signalled done
    a_done_leaves_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> (state_reg == wfrm_pkg::MD_IDLE))
        else $error("rate unit still busy after done");

endmodule

@@ hw/rtl/weighted_frame_rate_meter.sv @@
// top level of the weighted frame rate meter: frame counting, history, output
// depends on wfrm_pkg and wfrm_muldiv
`timescale 1ns / 1ps

// Each input transfer is one presented frame stamped with a free-running
// 32-bit tick count. A frame that does not close an interval is taken and gives
// no output. A frame whose elapsed ticks since the last update
// (modulo 2^16) reach the interval length register pushes the interval into the
// five-entry history, and its output carries the weighted rate in hundredths of
// a frame per second, saturated at 24 bits. The work behind it is serial:
// weighted sums over the history entries, launch of the rate unit, a bit-serial
// multiply by ticks_per_second, an overflow check, a bit-serial divide (skipped
// when the rate saturates) and the output load, which waits until the previous
// result has been taken. The next frame is taken as soon as that work is done,
// even while its result still waits on the output. History is cleared at
// reset.

module weighted_frame_rate_meter
(
    input  logic                              clk,
    input  logic                              rst_n,
    // frame_time [31:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,
    // rate_hundredths [23:0], interval_frames [39:24], interval_ticks [55:40]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [55:0]                       m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wfrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wfrm_pkg::CFG_DAT_W-1:0]    cfg_data
);

    localparam int D = wfrm_pkg::HISTORY_DEPTH;

    wfrm_pkg::state_t state_reg, state_next;

    logic [wfrm_pkg::TICK_W-1:0]  span_len_reg;
    logic [wfrm_pkg::TPS_W-1:0]   ticks_per_second_reg;
    logic [wfrm_pkg::FRAME_W-1:0] frame_count_reg;
    logic [wfrm_pkg::TIME_W-1:0]  last_tick_reg;
    logic [wfrm_pkg::FRAME_W-1:0] hist_frames_reg [D];
    logic [wfrm_pkg::TICK_W-1:0]  hist_ticks_reg [D];
    logic [wfrm_pkg::SUM_W-2:0]   acc_f_reg;
    logic [wfrm_pkg::SUM_W-2:0]   acc_t_reg;
    logic [wfrm_pkg::HCNT_W-1:0]  hcnt_reg;
    logic [wfrm_pkg::FRAME_W-1:0] pend_frames_reg;
    logic [wfrm_pkg::TICK_W-1:0]  pend_ticks_reg;
    logic                         m_tvalid_reg;
    logic [55:0]                  m_tdata_reg;

    logic                         in_xfer;
    logic                         out_xfer;
    logic [wfrm_pkg::FRAME_W-1:0] fc_inc;
    logic [wfrm_pkg::TICK_W-1:0]  elapsed;
    logic [wfrm_pkg::TIME_W-1:0]  diff_time;
    logic                         close;
    logic                         sum_last;
    logic                         md_start;
    logic                         load_out;
    logic [wfrm_pkg::RATE_W-1:0]  md_rate;
    wfrm_pkg::md_stat_t           md_stat;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid_reg && m_tready;
    assign fc_inc    = frame_count_reg + 1'b1;
    assign diff_time = s_tdata - last_tick_reg;
    assign elapsed   = diff_time[wfrm_pkg::TICK_W-1:0];
    assign close     = (elapsed >= span_len_reg);
    assign sum_last  = (hcnt_reg == wfrm_pkg::HCNT_W'(D - 1));
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_len_reg         <= wfrm_pkg::SPAN_LEN_RST;
            ticks_per_second_reg <= wfrm_pkg::TICKS_PER_SECOND_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                wfrm_pkg::REG_SPAN_LEN:         span_len_reg         <= cfg_data;
                wfrm_pkg::REG_TICKS_PER_SECOND: ticks_per_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfrm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and control strobes
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        md_start   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            wfrm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && close)
                begin
                    state_next = wfrm_pkg::ST_SUM;
                end
            end
            wfrm_pkg::ST_SUM:
            begin
                if (sum_last)
                begin
                    state_next = wfrm_pkg::ST_LAUNCH;
                end
            end
            wfrm_pkg::ST_LAUNCH:
            begin
                md_start   = 1'b1;
                state_next = wfrm_pkg::ST_CALC;
            end
            wfrm_pkg::ST_CALC:
            begin
                if (md_stat.done)
                begin
                    state_next = wfrm_pkg::ST_HOLD;
                end
            end
            wfrm_pkg::ST_HOLD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = wfrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wfrm_pkg::ST_IDLE;
            end
        endcase
    end

    // frame count, update tick and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            last_tick_reg   <= '0;
            for (int k = 0; k < D; k++)
            begin
                hist_frames_reg[k] <= '0;
                hist_ticks_reg[k]  <= '0;
            end
        end
        else if (in_xfer)
        begin
            if (close)
            begin
                frame_count_reg <= '0;
                last_tick_reg   <= s_tdata;
                for (int k = 0; k < D - 1; k++)
                begin
                    hist_frames_reg[k] <= hist_frames_reg[k+1];
                    hist_ticks_reg[k]  <= hist_ticks_reg[k+1];
                end
                hist_frames_reg[D-1] <= fc_inc;
                hist_ticks_reg[D-1]  <= elapsed;
            end
            else
            begin
                frame_count_reg <= fc_inc;
            end
        end
        else if (state_reg == wfrm_pkg::ST_SUM)
        begin
            // rotate so the newest entry comes first, back in place after D steps
            for (int k = 1; k < D; k++)
            begin
                hist_frames_reg[k] <= hist_frames_reg[k-1];
                hist_ticks_reg[k]  <= hist_ticks_reg[k-1];
            end
            hist_frames_reg[0] <= hist_frames_reg[D-1];
            hist_ticks_reg[0]  <= hist_ticks_reg[D-1];
        end
    end

    // horner weighted sums, half scale; newest entry enters first
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            acc_f_reg       <= '0;
            acc_t_reg       <= '0;
            hcnt_reg        <= '0;
            pend_frames_reg <= fc_inc;
            pend_ticks_reg  <= elapsed;
        end
        else if (state_reg == wfrm_pkg::ST_SUM)
        begin
            acc_f_reg <= {acc_f_reg[wfrm_pkg::SUM_W-3:0], 1'b0}
                       + (wfrm_pkg::SUM_W-1)'(hist_frames_reg[D-1]);
            acc_t_reg <= {acc_t_reg[wfrm_pkg::SUM_W-3:0], 1'b0}
                       + (wfrm_pkg::SUM_W-1)'(hist_ticks_reg[D-1]);
            hcnt_reg  <= hcnt_reg + 1'b1;
        end
    end

    wfrm_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .fsum  ({acc_f_reg, 1'b0}),
        .tsum  ({acc_t_reg, 1'b0}),
        .tps   (ticks_per_second_reg),
        .rate  (md_rate),
        .stat  (md_stat)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata_reg <= {pend_ticks_reg, pend_frames_reg, md_rate};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before transfer");

    // closing frame restarts the count
    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && close) |=> (frame_count_reg == '0))
        else $error("frame count not cleared on interval close");

    // the rate unit only reports done while the sequencer waits for it
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        md_stat.done |-> (state_reg == wfrm_pkg::ST_CALC))
        else $error("rate unit done outside of calc");

    // summing never runs past the history depth
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wfrm_pkg::ST_SUM) |-> (hcnt_reg <= wfrm_pkg::HCNT_W'(D - 1)))
        else $error("history sum ran past depth");

endmodule
